// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
// rsc_pkg: shared types, constants and wiring tables for the rotor
// substitution cipher. No dependencies.
package rsc_pkg;

  localparam int RSC_SLOTS = 4;    // number of rotor cells in the chain
  localparam int WIRING_CNT = 9;   // fixed rotors, table 0 is identity
  localparam int LETTERS = 26;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR = 3'd6;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // first letter sits in the top byte
  localparam logic [8*LETTERS-1:0] WIRING [WIRING_CNT] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } item_t;

  typedef struct packed {
    logic       en;
    logic [3:0] tbl;
    logic       dir;
    logic [4:0] rot;   // already reduced to 0..25
  } cell_ctl_t;

  // entry j of table t as a letter index; out-of-range tables are identity
  function automatic logic [4:0] wire_idx(input logic [3:0] t, input logic [4:0] j);
    logic [3:0] tt;
    logic [7:0] letter;
    tt = (t >= 4'(WIRING_CNT)) ? 4'd0 : t;
    letter = WIRING[tt][8*(LETTERS-1-int'(j)) +: 8];
    return 5'(letter - CHAR_A);
  endfunction

  // position whose entry in table t equals letter index c
  function automatic logic [4:0] inv_idx(input logic [3:0] t, input logic [4:0] c);
    logic [4:0] r;
    r = c;
    for (int j = 0; j < LETTERS; j++) begin
      if (wire_idx(t, 5'(j)) == c) r = 5'(j);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rsc_in_if.sv =====
`timescale 1ns / 1ps
// rsc_in_if: character input channel, valid/ready with one byte payload.
// No dependencies.
interface rsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

// ===== rtl/rsc_out_if.sv =====
`timescale 1ns / 1ps
// rsc_out_if: result channel, valid/ready with character and error flag.
// No dependencies.
interface rsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       bad_char;

  modport source (output valid, output out_char, output bad_char, input ready);
  modport sink (input valid, input out_char, input bad_char, output ready);
endinterface

// ===== rtl/rsc_cfg_if.sv =====
`timescale 1ns / 1ps
// rsc_cfg_if: configuration write channel (register index and data).
// Depends on rsc_pkg for field widths.
interface rsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data;

  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// ===== rtl/rsc_cell.sv =====
`timescale 1ns / 1ps
// rsc_cell: one rotor cell; substitutes a letter through one rotated table
// and registers the transaction for the next cell. Depends on rsc_pkg.
module rsc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rsc_pkg::cell_ctl_t ctl,
  input  logic               up_valid,
  input  rsc_pkg::item_t     up_item,
  output logic               up_ready,
  output logic               dn_valid,
  output rsc_pkg::item_t     dn_item,
  input  logic               dn_ready
);

  logic           valid_r, valid_nxt;
  rsc_pkg::item_t item_r, item_nxt;

  logic       is_letter;
  logic [4:0] k;
  logic [5:0] src6, bsum6;
  logic [4:0] src, fwd_res, inv_j, bwd_res, res;

  assign is_letter = (up_item.ch >= rsc_pkg::CHAR_A) && (up_item.ch <= rsc_pkg::CHAR_Z);
  assign k = 5'(up_item.ch - rsc_pkg::CHAR_A);

  // forward: wiring[(k - rot) mod 26]
  assign src6 = {1'b0, k} + 6'(rsc_pkg::LETTERS) - {1'b0, ctl.rot};
  assign src = (src6 >= 6'(rsc_pkg::LETTERS)) ? 5'(src6 - 6'(rsc_pkg::LETTERS)) : src6[4:0];
  assign fwd_res = rsc_pkg::wire_idx(ctl.tbl, src);

  // inverse: (j + rot) mod 26 where wiring[j] == k
  assign inv_j = rsc_pkg::inv_idx(ctl.tbl, k);
  assign bsum6 = {1'b0, inv_j} + {1'b0, ctl.rot};
  assign bwd_res = (bsum6 >= 6'(rsc_pkg::LETTERS)) ?
                   5'(bsum6 - 6'(rsc_pkg::LETTERS)) : bsum6[4:0];

  assign res = (ctl.dir == rsc_pkg::DIR_DEC) ? bwd_res : fwd_res;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt = item_r;
    if (up_ready) begin
      valid_nxt = up_valid;
      item_nxt.bad = up_item.bad;
      if (ctl.en && is_letter) begin
        item_nxt.ch = {3'b000, res} + rsc_pkg::CHAR_A;
      end else begin
        item_nxt.ch = up_item.ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_item = item_r;

endmodule

// ===== rtl/rotor_substitution_cipher.sv =====
`timescale 1ns / 1ps
// rotor_substitution_cipher: top level; configuration registers and a chain
// of rsc_cell stages. Depends on rsc_pkg, rsc_in_if, rsc_out_if, rsc_cfg_if.
//
// Usage:
//  - in_ch carries one ASCII byte per transaction; out_ch returns one result
//    byte plus bad_char per transaction, in order. Uppercase letters go through
//    up to four rotor tables, space passes, anything else passes with bad_char.
//  - cfg_bus writes register cfg_index with cfg_data: 0..3 slot tables,
//    4 active slot count, 5 rotation, 6 direction; index 7 is ignored.
//    cfg_bus.ready is always high. Write only while the block is empty.
//  - Each transaction passes through one register per rotor cell on its way
//    to the result; the last cell's register is the output.
//  - Throughput is one transaction per cycle unless out_ch stalls; each cell
//    handles one rotor slot and hands its result on to the next cell.
//  - When the receiver stalls, each cell holds its transaction and keeps
//    accepting until it is full, so up to 4 transactions queue before
//    in_ch.ready drops. No transaction is lost or repeated.
//  - Reset (rst_n low, synchronous) empties the chain and clears all
//    configuration registers to 0 (identity, no active slots, encrypt).
module rotor_substitution_cipher (
  input logic     clk,
  input logic     rst_n,
  rsc_in_if.sink  in_ch,
  rsc_out_if.source out_ch,
  rsc_cfg_if.sink cfg_bus
);

  localparam int N = rsc_pkg::RSC_SLOTS;

  // configuration registers
  logic [3:0] slot_a_r, slot_b_r, slot_c_r, slot_d_r;
  logic [2:0] active_r;
  logic [4:0] rot_r;
  logic       dir_r;

  logic cfg_wr;
  assign cfg_bus.ready = 1'b1;
  assign cfg_wr = cfg_bus.valid && cfg_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_a_r <= '0;
      slot_b_r <= '0;
      slot_c_r <= '0;
      slot_d_r <= '0;
      active_r <= '0;
      rot_r    <= '0;
      dir_r    <= rsc_pkg::DIR_ENC;
    end else if (cfg_wr) begin
      case (cfg_bus.cfg_index)
        rsc_pkg::CFG_SLOT_A: slot_a_r <= cfg_bus.cfg_data[3:0];
        rsc_pkg::CFG_SLOT_B: slot_b_r <= cfg_bus.cfg_data[3:0];
        rsc_pkg::CFG_SLOT_C: slot_c_r <= cfg_bus.cfg_data[3:0];
        rsc_pkg::CFG_SLOT_D: slot_d_r <= cfg_bus.cfg_data[3:0];
        rsc_pkg::CFG_ACTIVE: active_r <= cfg_bus.cfg_data[2:0];
        rsc_pkg::CFG_ROT:    rot_r    <= cfg_bus.cfg_data;
        rsc_pkg::CFG_DIR:    dir_r    <= cfg_bus.cfg_data[0];
        default: ;
      endcase
    end
  end

  // rotation wraps into 0..25, slot count saturates at the chain length
  logic [4:0] rot26;
  logic [2:0] limit;
  assign rot26 = (rot_r >= 5'(rsc_pkg::LETTERS)) ? 5'(rot_r - 5'(rsc_pkg::LETTERS)) : rot_r;
  assign limit = (active_r > 3'(N)) ? 3'(N) : active_r;

  function automatic logic [3:0] slot_tbl(input logic [1:0] s, input logic [3:0] a,
                                          input logic [3:0] b, input logic [3:0] c,
                                          input logic [3:0] d);
    logic [3:0] t;
    case (s)
      2'd0: t = a;
      2'd1: t = b;
      2'd2: t = c;
      default: t = d;
    endcase
    return t;
  endfunction

  // cell p runs slot p when encrypting, slot limit-1-p when decrypting
  rsc_pkg::cell_ctl_t ctl [N];
  always_comb begin
    for (int p = 0; p < N; p++) begin
      logic [1:0] s;
      s = (dir_r == rsc_pkg::DIR_DEC) ? 2'(limit - 3'd1 - 3'(p)) : 2'(p);
      ctl[p].en  = (3'(p) < limit);
      ctl[p].tbl = slot_tbl(s, slot_a_r, slot_b_r, slot_c_r, slot_d_r);
      ctl[p].dir = dir_r;
      ctl[p].rot = rot26;
    end
  end

  // the chain
  logic           vld [N+1];
  logic           rdy [N+1];
  rsc_pkg::item_t itm [N+1];

  assign vld[0] = in_ch.valid;
  assign itm[0].ch = in_ch.in_char;
  assign itm[0].bad = !((in_ch.in_char >= rsc_pkg::CHAR_A) && (in_ch.in_char <= rsc_pkg::CHAR_Z))
                      && (in_ch.in_char != rsc_pkg::CHAR_SPACE);
  assign in_ch.ready = rdy[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    rsc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .up_valid (vld[g]),
      .up_item  (itm[g]),
      .up_ready (rdy[g]),
      .dn_valid (vld[g+1]),
      .dn_item  (itm[g+1]),
      .dn_ready (rdy[g+1])
    );
  end

  assign rdy[N] = out_ch.ready;
  assign out_ch.valid = vld[N];
  assign out_ch.out_char = itm[N].ch;
  assign out_ch.bad_char = itm[N].bad;

  // a letter result never carries the error flag
  a_letter_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_char >= rsc_pkg::CHAR_A && out_ch.out_char <= rsc_pkg::CHAR_Z)
    |-> !out_ch.bad_char)
    else $error("letter result flagged bad");

  // a space result is never flagged
  a_space_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_char == rsc_pkg::CHAR_SPACE) |-> !out_ch.bad_char)
    else $error("space result flagged bad");

  // input backpressure only when every cell is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (vld[1] && vld[2] && vld[3] && vld[4]))
    else $error("input stalled with an empty cell");

  // an accepted transaction lands in the first cell
  a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld[1])
    else $error("accepted transaction missing in first cell");

endmodule
